// ----- design/ste_pkg.sv -----
// Shared types, codes and constants for the sorted table engine.
`default_nettype none

package ste_pkg;

    localparam int DEPTH_DEF = 256;

    localparam logic [8:0] CAP_RESET = 9'd256;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    // read address source
    localparam logic [1:0] RD_DN = 2'd0;  // next pointer minus one
    localparam logic [1:0] RD_UP = 2'd1;  // next pointer plus one
    localparam logic [1:0] RD_IX = 2'd2;  // request index

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key;
        logic [7:0]  index;
    } t_in_word;

    typedef struct packed {
        logic [63:0] value;
        logic [8:0]  count;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SCAN,
        S_INS_KEY,
        S_REM_SHIFT,
        S_REM_END,
        S_LK_DATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] rd_mode;
        logic       ptr_dec;
        logic       ptr_inc;
        logic       wr_shift;
        logic       wr_key;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_stat;
        logic [1:0] stat;
        logic       lk_cap;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       bad_idx;
        logic       ptr_zero;
        logic       ptr_one;
        logic       rem_last;
        logic       rem_last2;
        logic       data_ge;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- design/ste_ctrl.sv -----
// Sequencer for insert, lookup and remove passes over the table memory.
`default_nettype none

module ste_ctrl
    import ste_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.full)          n_state = S_DONE;
                        else if (i_stat.ptr_zero) n_state = S_INS_KEY;
                        else                      n_state = S_INS_SCAN;
                    end
                    OP_LOOKUP: begin
                        n_state = i_stat.bad_idx ? S_DONE : S_LK_DATA;
                    end
                    OP_REMOVE: begin
                        if (i_stat.bad_idx)       n_state = S_DONE;
                        else if (i_stat.rem_last) n_state = S_REM_END;
                        else                      n_state = S_REM_SHIFT;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_INS_SCAN: begin
                if (!i_stat.data_ge || i_stat.ptr_one) n_state = S_INS_KEY;
            end
            S_INS_KEY:   n_state = S_DONE;
            S_REM_SHIFT: begin
                if (i_stat.rem_last2) n_state = S_REM_END;
            end
            S_REM_END:   n_state = S_DONE;
            S_LK_DATA:   n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.set_stat = 1'b1;
                o_cmd.stat     = ST_OK;
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.stat = ST_FULL;
                        end else if (!i_stat.ptr_zero) begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_mode = RD_DN;
                        end
                    end
                    OP_LOOKUP: begin
                        if (i_stat.bad_idx) begin
                            o_cmd.stat = ST_BAD_INDEX;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_mode = RD_IX;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.bad_idx) begin
                            o_cmd.stat = ST_BAD_INDEX;
                        end else if (!i_stat.rem_last) begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_mode = RD_UP;
                        end
                    end
                    default: o_cmd.stat = ST_OK;
                endcase
            end
            S_INS_SCAN: begin
                // entry below the hole is not less than the key: move it up
                if (i_stat.data_ge) begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.ptr_dec  = 1'b1;
                    if (!i_stat.ptr_one) begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_mode = RD_DN;
                    end
                end
            end
            S_INS_KEY: begin
                o_cmd.wr_key  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            S_REM_SHIFT: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
                if (!i_stat.rem_last2) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_mode = RD_UP;
                end
            end
            S_REM_END: o_cmd.cnt_dec = 1'b1;
            S_LK_DATA: o_cmd.lk_cap  = 1'b1;
            S_DONE:    o_cmd.out_load = i_stat.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/ste_dpath.sv -----
// Table memory, count, capacity register, pointer and result register.
`default_nettype none

module ste_dpath
    import ste_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_word i_in_word,
    input  wire logic     i_cfg_we,
    input  wire logic [8:0] i_cfg_data,
    input  wire logic     i_out_ready,
    output logic          o_out_valid,
    output t_out_word     o_out_word,
    input  wire t_cmd     i_cmd,
    output t_stat         o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > 9) ? CW : 9) + 1;

    logic [63:0] r_mem [DEPTH];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] n_ptr;
    logic [8:0]    r_cap;
    logic [1:0]    r_op;
    logic [63:0]   r_key;
    logic [7:0]    r_idx;
    logic [63:0]   r_rdata;
    logic [63:0]   r_val;
    logic [1:0]    r_stat;
    logic          r_out_valid;
    t_out_word     r_out;

    logic [WW-1:0] limit_w;
    logic [WW-1:0] count_w;
    logic [CW:0]   ptr_p1;
    logic [CW:0]   ptr_p2;
    logic [CW-1:0] addr_w;
    logic [AW-1:0] rd_addr;
    logic [63:0]   wr_data;
    logic          out_free;

    assign count_w  = WW'(r_count);
    assign limit_w  = (WW'(r_cap) > WW'(DEPTH)) ? WW'(DEPTH) : WW'(r_cap);
    assign ptr_p1   = {1'b0, r_ptr} + (CW+1)'(1);
    assign ptr_p2   = {1'b0, r_ptr} + (CW+1)'(2);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat           = '0;
        o_stat.op        = r_op;
        o_stat.full      = count_w >= limit_w;
        o_stat.bad_idx   = WW'(r_idx) >= count_w;
        o_stat.ptr_zero  = r_ptr == '0;
        o_stat.ptr_one   = r_ptr == CW'(1);
        o_stat.rem_last  = ptr_p1 >= {1'b0, r_count};
        o_stat.rem_last2 = ptr_p2 >= {1'b0, r_count};
        o_stat.data_ge   = r_rdata >= r_key;
        o_stat.out_free  = out_free;
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.load) begin
            n_ptr = (i_in_word.opcode == OP_INSERT) ? r_count : CW'(i_in_word.index);
        end else if (i_cmd.ptr_dec) begin
            n_ptr = r_ptr - CW'(1);
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + CW'(1);
        end
    end

    always_comb begin
        case (i_cmd.rd_mode)
            RD_DN:   addr_w = n_ptr - CW'(1);
            RD_UP:   addr_w = n_ptr + CW'(1);
            RD_IX:   addr_w = CW'(r_idx);
            default: addr_w = n_ptr;
        endcase
        rd_addr = addr_w[AW-1:0];
        wr_data = i_cmd.wr_key ? r_key : r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift || i_cmd.wr_key) begin
            r_mem[r_ptr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_op  <= i_in_word.opcode;
            r_key <= i_in_word.key;
            r_idx <= i_in_word.index;
            r_val <= '0;
        end else if (i_cmd.lk_cap) begin
            r_val <= r_rdata;
        end
        if (i_cmd.set_stat) r_stat <= i_cmd.stat;
        if (i_cmd.out_load) begin
            r_out.value  <= r_val;
            r_out.count  <= count_w[8:0];
            r_out.status <= r_stat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_count) <= WW'(DEPTH))
        else $error("entry count above depth");
    a_inc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (count_w < limit_w))
        else $error("insert committed on a full table");
    a_dec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> (r_count != '0))
        else $error("remove committed on an empty table");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result word overwritten before taken");
`endif

endmodule

`default_nettype wire

// ----- design/sorted_table_engine.sv -----
// Sorted table engine: keeps up to DEPTH 64-bit keys in ascending unsigned
// order. Words are taken one at a time. An insert moves each stored entry
// not less than the key up by one place and then writes the key into the
// hole; a remove moves each entry above the removed index down by one
// place. A lookup reads the entry at the request index, and a refused
// request or an unused opcode touches no entry. One entry moves per cycle
// through the memory's single write and single registered read port. The
// table memory needs no clearing pass after reset; only the count, the
// capacity register and the output valid flag are reset. The capacity
// register may be written at any idle time and takes effect at once.
`default_nettype none

module sorted_table_engine
    import ste_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_word   i_in_word,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_word       o_out_word,
    input  wire logic       i_cfg_we,
    input  wire logic [8:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    ste_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ste_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire
